>>> rtl/csv_field_tokenizer_macros.svh
// Assertion helpers for the tokenizer RTL.
`ifndef CSV_FIELD_TOKENIZER_MACROS_SVH
`define CSV_FIELD_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cft assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cft assertion failed");

`endif

>>> rtl/cft_pkg.sv
`default_nettype none

package cft_pkg;

	localparam int BYTE_W      = 8;
	localparam int COL_W       = 8;
	localparam int HDR_W       = 9;
	localparam int ROW_W       = 24;
	localparam int CFG_INDEX_W = 8;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_DELIMITER  = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_QUOTE_CHAR = 8'd1;

	localparam logic [BYTE_W-1:0] DEFAULT_DELIMITER = 8'd44; // ','
	localparam logic [BYTE_W-1:0] DEFAULT_QUOTE     = 8'd34; // '"'
	localparam logic [BYTE_W-1:0] CHAR_LF           = 8'd10;
	localparam logic [BYTE_W-1:0] CHAR_CR           = 8'd13;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// Classified byte, as handed from the front to the back
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              is_quote;
		logic              is_delim;
		logic              is_lf;
		logic              is_cr;
	} cft_tok_t;

	typedef struct packed {
		logic     valid;
		cft_tok_t tok;
	} cft_slot_t;

endpackage

`default_nettype wire

>>> rtl/cft_ifs.sv
`default_nettype none

interface cft_in_if;
	logic                     valid;
	logic                     ready;
	logic [cft_pkg::BYTE_W-1:0] in_byte;
	logic                     in_last;

	modport source (output valid, in_byte, in_last, input ready);
	modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface cft_out_if;
	logic                       valid;
	logic                       ready;
	logic [cft_pkg::BYTE_W-1:0] out_byte;
	logic                       has_byte;
	logic                       field_end;
	logic                       row_end;
	logic [cft_pkg::COL_W-1:0]  column_index;
	logic [cft_pkg::ROW_W-1:0]  row_index;
	logic                       extra_field;
	logic [cft_pkg::HDR_W-1:0]  header_columns;

	modport source (output valid, out_byte, has_byte, field_end, row_end, column_index,
		row_index, extra_field, header_columns, input ready);
	modport sink   (input valid, out_byte, has_byte, field_end, row_end, column_index,
		row_index, extra_field, header_columns, output ready);
endinterface

interface cft_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [cft_pkg::CFG_INDEX_W-1:0] index;
	logic [cft_pkg::BYTE_W-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/csv_field_tokenizer.sv
// Channel   Direction  Payload                                   Transaction when
// text      in         in_byte, in_last                          text.valid && text.ready
// cfg       in         index, data (0 delimiter, 1 quote_char)   cfg.valid && cfg.ready
// tokens    out        out_byte .. header_columns                tokens.valid && tokens.ready
//
// One byte per cycle while tokens is not stalled; a byte that makes a result is
// written to the queue and then to the output register before it shows on tokens.
// The front classifies bytes against the delimiter, quote, LF and CR; a two-entry queue
// separates it from the back, which holds quote parity and the counters.
// Reset clears all control state and restores delimiter ',' and quote '"'.
// A stall on tokens backs up the queue; text.ready drops only when it is full.
// cfg.ready is always high; write configuration only while no byte is in flight.
`default_nettype none

module csv_field_tokenizer #(
	parameter int MAX_COLUMNS    = 256,
	parameter int ROW_INDEX_BITS = 24
) (
	input  wire logic clk,
	input  wire logic arst_n,
	cft_in_if.sink    text,
	cft_cfg_if.sink   cfg,
	cft_out_if.source tokens
);

	// Push side of the queue and the slot at its head
	cft_pkg::cft_slot_t push;
	cft_pkg::cft_slot_t head;
	logic               full;
	logic               pop;

	// Classify each byte and hold the configuration registers
	cft_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.cfg    (cfg),
		.push   (push),
		.full   (full)
	);

	// Decouple classification from parsing so each side can stall on its own
	cft_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.head   (head),
		.pop    (pop)
	);

	// Track quote parity, columns and rows; drive the result register
	cft_back #(
		.MAX_COLUMNS    (MAX_COLUMNS),
		.ROW_INDEX_BITS (ROW_INDEX_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.tokens (tokens)
	);

endmodule

`default_nettype wire

>>> rtl/cft_front.sv
`default_nettype none

module cft_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	cft_in_if.sink             text,
	cft_cfg_if.sink            cfg,
	output cft_pkg::cft_slot_t push,
	input  wire logic          full
);

	logic [cft_pkg::BYTE_W-1:0] delim_q;
	logic [cft_pkg::BYTE_W-1:0] quote_q;
	logic [cft_pkg::BYTE_W-1:0] delim_eff;
	logic [cft_pkg::BYTE_W-1:0] quote_eff;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= cft_pkg::DEFAULT_DELIMITER;
			quote_q <= cft_pkg::DEFAULT_QUOTE;
		end else if (cfg.valid) begin
			if (cfg.index == cft_pkg::REG_DELIMITER) begin
				delim_q <= cfg.data;
			end
			if (cfg.index == cft_pkg::REG_QUOTE_CHAR) begin
				quote_q <= cfg.data;
			end
		end
	end

	// A zero register value falls back to the default character
	assign delim_eff = (delim_q == '0) ? cft_pkg::DEFAULT_DELIMITER : delim_q;
	assign quote_eff = (quote_q == '0) ? cft_pkg::DEFAULT_QUOTE : quote_q;

	assign text.ready = !full;

	always_comb begin
		push.valid        = text.valid && !full;
		push.tok.data     = text.in_byte;
		push.tok.last     = text.in_last;
		push.tok.is_quote = (text.in_byte == quote_eff);
		push.tok.is_delim = (text.in_byte == delim_eff);
		push.tok.is_lf    = (text.in_byte == cft_pkg::CHAR_LF);
		push.tok.is_cr    = (text.in_byte == cft_pkg::CHAR_CR);
	end

endmodule

`default_nettype wire

>>> rtl/cft_queue.sv
`default_nettype none

module cft_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cft_pkg::cft_slot_t push,
	output logic                    full,
	output cft_pkg::cft_slot_t      head,
	input  wire logic               pop
);

	cft_pkg::cft_tok_t           mem [cft_pkg::QUEUE_DEPTH];
	logic [cft_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [cft_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [cft_pkg::QCNT_W-1:0]  count_q;
	logic                        do_push;
	logic                        do_pop;

	assign full       = (count_q == cft_pkg::QCNT_W'(cft_pkg::QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.tok   = mem[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push.tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/cft_back.sv
`default_nettype none
`include "csv_field_tokenizer_macros.svh"

module cft_back #(
	parameter int MAX_COLUMNS    = 256,
	parameter int ROW_INDEX_BITS = 24
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cft_pkg::cft_slot_t head,
	output logic                    pop,
	cft_out_if.source               tokens
);

	localparam int COL_SAT = (MAX_COLUMNS - 1 < 255) ? MAX_COLUMNS - 1 : 255;
	localparam int RW      = (ROW_INDEX_BITS < cft_pkg::ROW_W) ? ROW_INDEX_BITS
		: cft_pkg::ROW_W;

	// Parser state
	logic                        iq_q;
	logic                        pwq_q;
	logic                        fo_q;
	logic                        frd_q;
	logic [cft_pkg::COL_W-1:0]   col_q;
	logic [RW-1:0]               row_q;
	logic [cft_pkg::HDR_W-1:0]   hdr_q;

	// Output register
	logic                        ovalid_q;
	logic [cft_pkg::BYTE_W-1:0]  obyte_q;
	logic                        ohas_q;
	logic                        ofend_q;
	logic                        orend_q;
	logic [cft_pkg::COL_W-1:0]   ocol_q;
	logic [RW-1:0]               orow_q;
	logic                        oextra_q;
	logic [cft_pkg::HDR_W-1:0]   ohdr_q;

	logic                        has;
	logic                        fend;
	logic                        rend;
	logic [cft_pkg::BYTE_W-1:0]  res_byte;
	logic                        iq_d;
	logic                        pwq_d;
	logic                        fo_d;
	logic                        emit;
	logic                        extra;
	cft_pkg::cft_tok_t           t;

	assign t     = head.tok;
	assign pop   = head.valid && (!ovalid_q || tokens.ready);
	assign extra = frd_q && ({1'b0, col_q} >= hdr_q);

	always_comb begin
		has      = 1'b0;
		fend     = 1'b0;
		rend     = 1'b0;
		res_byte = '0;
		iq_d     = iq_q;
		pwq_d    = pwq_q;
		fo_d     = fo_q;
		if (t.is_quote) begin
			if (pwq_q) begin
				has      = 1'b1;
				res_byte = t.data;
				iq_d     = 1'b1;
				pwq_d    = 1'b0;
			end else begin
				pwq_d = iq_q;
				iq_d  = !iq_q;
			end
			fo_d = 1'b1;
		end else begin
			pwq_d = 1'b0;
			if (!iq_q && t.is_delim) begin
				fend = 1'b1;
			end else if (!iq_q && t.is_lf) begin
				fend = 1'b1;
				rend = 1'b1;
			end else if (!iq_q && t.is_cr) begin
				fend = 1'b0;
			end else begin
				has      = 1'b1;
				res_byte = t.data;
				fo_d     = 1'b1;
			end
		end
		// Last byte closes whatever field is open
		if (t.last && !rend && (fend || fo_d)) begin
			fend = 1'b1;
			rend = 1'b1;
		end
		if (rend) begin
			fo_d = 1'b0;
		end else if (fend) begin
			fo_d = 1'b1;
		end
		if (t.last) begin
			iq_d  = 1'b0;
			pwq_d = 1'b0;
			fo_d  = 1'b0;
		end
		emit = has || fend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iq_q  <= 1'b0;
			pwq_q <= 1'b0;
			fo_q  <= 1'b0;
			frd_q <= 1'b0;
			col_q <= '0;
			row_q <= '0;
			hdr_q <= '0;
		end else if (pop) begin
			iq_q  <= iq_d;
			pwq_q <= pwq_d;
			fo_q  <= fo_d;
			if (rend) begin
				if (!frd_q) begin
					hdr_q <= {1'b0, col_q} + 1'b1;
					frd_q <= 1'b1;
				end
				col_q <= '0;
				if (row_q != '1) begin
					row_q <= row_q + 1'b1;
				end
			end else if (fend) begin
				if (col_q < cft_pkg::COL_W'(COL_SAT)) begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (pop && emit) begin
			ovalid_q <= 1'b1;
		end else if (tokens.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			obyte_q  <= res_byte;
			ohas_q   <= has;
			ofend_q  <= fend;
			orend_q  <= rend;
			ocol_q   <= col_q;
			orow_q   <= row_q;
			oextra_q <= extra;
			ohdr_q   <= hdr_q;
		end
	end

	assign tokens.valid          = ovalid_q;
	assign tokens.out_byte       = obyte_q;
	assign tokens.has_byte       = ohas_q;
	assign tokens.field_end      = ofend_q;
	assign tokens.row_end        = orend_q;
	assign tokens.column_index   = ocol_q;
	assign tokens.row_index      = cft_pkg::ROW_W'(orow_q);
	assign tokens.extra_field    = oextra_q;
	assign tokens.header_columns = ohdr_q;

	`CFT_ASSERT_NOW(a_pwq_outside, clk, arst_n, pwq_q, !iq_q)
	`CFT_ASSERT_NOW(a_hdr_learned, clk, arst_n, frd_q, hdr_q != '0)
	`CFT_ASSERT_NOW(a_hdr_unknown, clk, arst_n, !frd_q, hdr_q == '0)
	`CFT_ASSERT_NEXT(a_last_clears, clk, arst_n, pop && t.last, !iq_q && !pwq_q && !fo_q)

endmodule

`default_nettype wire
